[rtl/core/wisd_pkg.sv]
// Shared types and fixed field widths for the WiSARD discriminator.
package wisd_pkg;

    // Fixed field widths of the input and result transactions
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned SCORE_W  = 5;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 16;

    // Saturation limits of the score and the trained position count
    localparam logic [SCORE_W-1:0] SCORE_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Operation carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_TRAIN   = 2'd0,
        MODE_RANK    = 2'd1,
        MODE_MAP_WR  = 2'd2
    } mode_t;

endpackage

[rtl/core/wisard_discriminator.sv]
// Top level of the WiSARD discriminator: stream handshake, stage and result registers.
//
// Input channel (s_): one transaction per item. s_tuser carries the operation
// (train, rank, map write); s_tdata carries the vector and the map entry fields.
// Result channel (m_): one transaction per rank item only, with the score and
// the count of trained positions. Train, map write and unused operations give
// no result.
// A rank item passes through the stage register and then the result register before m_ shows it.
// Throughput: one item per cycle unless a rank item waits on a held result; the stage
// register feeds one pass of permutation, node lookup and counting, whose state updates
// land at the same edge, so every item sees all state changes of the items before it.
// Reset: the map returns to identity, every node bit and the position count
// clear, and the stage and the result channel drop valid.
// Stall: a waiting result holds m_; one further item is still taken into the
// stage register, and a rank item behind the held result waits there, which
// drops s_tready. Train and map items pass through the stage regardless.
module wisard_discriminator #(
    parameter int unsigned ENTRY_BITS = 64,
    parameter int unsigned TUPLE_BITS = 4,
    parameter int unsigned NUM_NODES  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] data_bits, [69:64] map_index, [75:70] map_source, [79:76] zero
    input  logic [wisd_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [wisd_pkg::MODE_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] score, [13:5] trained_positions, [15:14] zero
    output logic [wisd_pkg::M_DATA_W-1:0] m_tdata
);

    logic                               stg_valid_reg;
    wisd_pkg::mode_t                    stg_mode_reg;
    logic [wisd_pkg::DATA_W-1:0]        stg_data_reg;
    logic [wisd_pkg::IDX_W-1:0]         stg_index_reg;
    logic [wisd_pkg::IDX_W-1:0]         stg_source_reg;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [wisd_pkg::SCORE_W-1:0]       m_score_reg;
    logic [wisd_pkg::COUNT_W-1:0]       m_count_reg;
    logic                               out_free;
    logic                               proc;
    logic                               is_rank;
    logic                               do_train;
    logic                               do_map_wr;
    logic                               s_take;
    logic [ENTRY_BITS-1:0]              perm_bits;
    logic [wisd_pkg::SCORE_W-1:0]       score;
    logic [wisd_pkg::COUNT_W-1:0]       count;

    // Advance the stage when its item needs no output slot or one is free
    always_comb begin
        out_free     = !m_valid_reg || m_tready;
        is_rank      = (stg_mode_reg == wisd_pkg::MODE_RANK);
        proc         = stg_valid_reg && (!is_rank || out_free);
        do_train     = proc && (stg_mode_reg == wisd_pkg::MODE_TRAIN);
        do_map_wr    = proc && (stg_mode_reg == wisd_pkg::MODE_MAP_WR);
        s_tready     = !stg_valid_reg || proc;
        s_take       = s_tvalid && s_tready;
        m_valid_next = m_valid_reg && !m_tready;
        if (proc && is_rank) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_take) begin
                stg_valid_reg <= 1'b1;
            end else if (proc) begin
                stg_valid_reg <= 1'b0;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (s_take) begin
            stg_mode_reg   <= wisd_pkg::mode_t'(s_tuser);
            stg_data_reg   <= s_tdata[63:0];
            stg_index_reg  <= s_tdata[69:64];
            stg_source_reg <= s_tdata[75:70];
        end
    end

    // Load the result register on a rank pass
    always_ff @(posedge aclk) begin
        if (proc && is_rank) begin
            m_score_reg <= score;
            m_count_reg <= count;
        end
    end

    wisd_map #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (do_map_wr),
        .wr_index  (stg_index_reg),
        .wr_source (stg_source_reg),
        .data_bits (stg_data_reg),
        .perm_bits (perm_bits)
    );

    wisd_nodes #(
        .ENTRY_BITS (ENTRY_BITS),
        .TUPLE_BITS (TUPLE_BITS),
        .NUM_NODES  (NUM_NODES)
    ) u_nodes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .train     (do_train),
        .perm_bits (perm_bits),
        .score     (score),
        .count     (count)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_score_reg};

endmodule

[rtl/core/wisd_map.sv]
// Loadable bit position map and the permutation of the input vector.
module wisd_map #(
    parameter int unsigned ENTRY_BITS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [wisd_pkg::IDX_W-1:0]  wr_index,
    input  logic [wisd_pkg::IDX_W-1:0]  wr_source,
    input  logic [wisd_pkg::DATA_W-1:0] data_bits,
    output logic [ENTRY_BITS-1:0]       perm_bits
);

    // One source index per permuted position; positions past the entry are never read
    logic [wisd_pkg::IDX_W-1:0] map_reg [ENTRY_BITS];

    // Reset to identity, overwrite one entry on a map write
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRY_BITS; i++) begin
            if (!aresetn) begin
                map_reg[i] <= wisd_pkg::IDX_W'(i);
            end else if (wr_en && (wr_index == wisd_pkg::IDX_W'(i))) begin
                map_reg[i] <= wr_source;
            end
        end
    end

    // Select each permuted bit from the vector
    always_comb begin
        for (int i = 0; i < ENTRY_BITS; i++) begin
            perm_bits[i] = data_bits[map_reg[i]];
        end
    end

endmodule

[rtl/core/wisd_nodes.sv]
// RAM nodes: tuple addressing, training, ranking and the trained position count.
module wisd_nodes #(
    parameter int unsigned ENTRY_BITS = 64,
    parameter int unsigned TUPLE_BITS = 4,
    parameter int unsigned NUM_NODES  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         train,
    input  logic [ENTRY_BITS-1:0]        perm_bits,
    output logic [wisd_pkg::SCORE_W-1:0] score,
    output logic [wisd_pkg::COUNT_W-1:0] count
);

    localparam int unsigned NODE_SIZE = 1 << TUPLE_BITS;
    localparam int unsigned HIT_W     = $clog2(NUM_NODES + 1);
    localparam int unsigned SUM_W     = wisd_pkg::COUNT_W + 1;

    logic [NODE_SIZE-1:0]  node_reg [NUM_NODES];
    logic [TUPLE_BITS-1:0] node_addr [NUM_NODES];
    logic [NUM_NODES-1:0]  hit;
    logic [HIT_W-1:0]      hit_cnt;
    logic [HIT_W-1:0]      new_cnt;
    logic [SUM_W-1:0]      hit_ext;
    logic [SUM_W-1:0]      count_sum;
    logic [wisd_pkg::COUNT_W-1:0] count_reg;
    logic [wisd_pkg::COUNT_W-1:0] count_next;

    // Build each tuple address, first mapped bit as MSB, zero past the entry
    for (genvar n = 0; n < NUM_NODES; n++) begin : g_node
        for (genvar j = 0; j < TUPLE_BITS; j++) begin : g_bit
            localparam int unsigned POS = n * TUPLE_BITS + j;
            if (POS < ENTRY_BITS) begin : g_in
                assign node_addr[n][TUPLE_BITS-1-j] = perm_bits[POS];
            end else begin : g_pad
                assign node_addr[n][TUPLE_BITS-1-j] = 1'b0;
            end
        end
        assign hit[n] = node_reg[n][node_addr[n]];
    end

    // Count addressed bits already set and those about to be set
    always_comb begin
        hit_cnt   = HIT_W'($countones(hit));
        new_cnt   = HIT_W'($countones(~hit));
        hit_ext   = SUM_W'(hit_cnt);
        count_sum = SUM_W'(count_reg) + SUM_W'(new_cnt);
        if (count_sum > SUM_W'(wisd_pkg::COUNT_MAX)) begin
            count_next = wisd_pkg::COUNT_MAX;
        end else begin
            count_next = count_sum[wisd_pkg::COUNT_W-1:0];
        end
        if (hit_ext > SUM_W'(wisd_pkg::SCORE_MAX)) begin
            score = wisd_pkg::SCORE_MAX;
        end else begin
            score = hit_ext[wisd_pkg::SCORE_W-1:0];
        end
    end

    // Set the addressed bit of every node on training and update the position count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_NODES; n++) begin
                node_reg[n] <= '0;
            end
            count_reg <= '0;
        end else if (train) begin
            for (int n = 0; n < NUM_NODES; n++) begin
                node_reg[n][node_addr[n]] <= 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule
